FILE: design/dpt_pkg.sv
// Shared types, constants and codes of the detection persistence table.
package dpt_pkg;

	localparam int ENTRIES    = 16;
	localparam int COORD_BITS = 10;

	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);
	localparam int MARGIN_W   = 10;
	localparam int CONFIRM_W  = 4;
	localparam int HIT_W      = 4;
	localparam int SLOT_W     = 4;
	localparam int REM_W      = 5;
	localparam int EVENT_W    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = (MARGIN_W > CONFIRM_W) ? MARGIN_W : CONFIRM_W;
	localparam int CMP_W      = (COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W;

	localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = MARGIN_W'(20);
	localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = CONFIRM_W'(10);
	localparam logic [REM_W-1:0]     REM_MAX       = '1;

	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_EOF   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MARGIN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = CFG_IDX_W'(1);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_MATCHED      = 3'd0,
		EV_CONFIRMED    = 3'd1,
		EV_NEW_ENTRY    = 3'd2,
		EV_TABLE_FULL   = 3'd3,
		EV_FRAME_CLOSED = 3'd4
	} event_t;

	// Search word that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic   active;
		logic   action;
		coord_t px;
		coord_t py;
		logic   found;
		idx_t   hit_slot;
		coord_t hit_x;
		coord_t hit_y;
		event_t ev;
		logic   have_free;
		idx_t   free_slot;
		cnt_t   freed;
	} wave_t;

	// Broadcast request that opens a new entry in one cell.
	typedef struct packed {
		logic   en;
		idx_t   slot;
		coord_t x;
		coord_t y;
	} alloc_t;

endpackage

FILE: design/dpt_cell.sv
// One table entry with its match, hit-count and end-of-frame logic.
module dpt_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpt_pkg::idx_t                       cell_idx,
	input  logic [dpt_pkg::MARGIN_W-1:0]        margin,
	input  logic [dpt_pkg::CONFIRM_W-1:0]       confirm,
	input  dpt_pkg::wave_t                      wave_in,
	input  dpt_pkg::alloc_t                     alloc,
	output dpt_pkg::wave_t                      wave_out
);

	logic                          valid_q, valid_d;
	logic                          seen_q, seen_d;
	dpt_pkg::coord_t               x_q, x_d;
	dpt_pkg::coord_t               y_q, y_d;
	logic [dpt_pkg::HIT_W-1:0]     count_q, count_d;
	logic [dpt_pkg::HIT_W-1:0]     count_inc;
	dpt_pkg::wave_t                wave_q, wave_d;
	dpt_pkg::coord_t               dx, dy;
	logic                          match;
	logic                          drop;

	always_comb begin
		dx = (wave_in.px > x_q) ? (wave_in.px - x_q) : (x_q - wave_in.px);
		dy = (wave_in.py > y_q) ? (wave_in.py - y_q) : (y_q - wave_in.py);
		match = valid_q
			&& (dpt_pkg::CMP_W'(dx) < dpt_pkg::CMP_W'(margin))
			&& (dpt_pkg::CMP_W'(dy) < dpt_pkg::CMP_W'(margin));
		count_inc = count_q + dpt_pkg::HIT_W'(1);
		drop = valid_q && !seen_q && (count_q <= dpt_pkg::HIT_W'(1));
	end

	always_comb begin
		valid_d = valid_q;
		seen_d  = seen_q;
		x_d     = x_q;
		y_d     = y_q;
		count_d = count_q;
		wave_d  = wave_in;
		if (wave_in.active) begin
			if (wave_in.action == dpt_pkg::ACT_EOF) begin
				seen_d = 1'b0;
				if (drop) begin
					valid_d = 1'b0;
					count_d = '0;
					wave_d.freed = wave_in.freed + dpt_pkg::cnt_t'(1);
				end else if (valid_q && !seen_q) begin
					count_d = count_q - dpt_pkg::HIT_W'(1);
				end
			end else if (match) begin
				seen_d = 1'b1;
				// Only the lowest matching slot takes the hit.
				if (!wave_in.found) begin
					wave_d.found    = 1'b1;
					wave_d.hit_slot = cell_idx;
					wave_d.hit_x    = x_q;
					wave_d.hit_y    = y_q;
					wave_d.ev       = dpt_pkg::EV_MATCHED;
					if (dpt_pkg::HIT_W'(count_q) < dpt_pkg::HIT_W'(confirm)) begin
						count_d = count_inc;
						if (count_inc == dpt_pkg::HIT_W'(confirm))
							wave_d.ev = dpt_pkg::EV_CONFIRMED;
					end
				end
			end else if (!valid_q && !wave_in.have_free) begin
				wave_d.have_free = 1'b1;
				wave_d.free_slot = cell_idx;
			end
		end
		if (alloc.en && (alloc.slot == cell_idx)) begin
			valid_d = 1'b1;
			seen_d  = 1'b1;
			x_d     = alloc.x;
			y_d     = alloc.y;
			count_d = dpt_pkg::HIT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seen_q  <= 1'b0;
			wave_q  <= '0;
		end else begin
			valid_q <= valid_d;
			seen_q  <= seen_d;
			wave_q  <= wave_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q     <= x_d;
		y_q     <= y_d;
		count_q <= count_d;
	end

	assign wave_out = wave_q;

endmodule

FILE: design/detection_persistence_table_core.sv
// Top level of the detection persistence table: cell row, result stage, config.
//
// The block keeps a table of tracked detection positions and confirms an
// object once it has been hit often enough. Input words arrive on the
// in_valid / in_ready channel: action 0 carries a detected point, action 1
// closes the current frame. Each input word yields exactly one result word
// on the out_valid / out_ready channel, in order.
// An accepted word enters a row of ENTRIES cells as a search word and moves
// one cell per cycle; each cell compares, counts or ages its own entry as
// the word passes. Opening a new entry is done after the walk, in one write
// to the lowest free cell. The result passes from the last cell into the
// walk result register and then into the output register, and a new word
// is taken only once the previous result has moved into the output register.
// A finished result sits in the output register while the next input word
// is already taken; if the receiver stalls, the walk result waits in a
// holding register and the block takes no further word until it moves on.
// Reset clears all entries and seen marks and loads match_margin = 20 and
// confirm_count = 10. The configuration port writes a register at every
// edge with cfg_we high; write only while the block is idle.
module detection_persistence_table_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dpt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dpt_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [dpt_pkg::COORD_BITS-1:0]        point_x,
	input  logic [dpt_pkg::COORD_BITS-1:0]        point_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [dpt_pkg::EVENT_W-1:0]           event_res,
	output logic [dpt_pkg::SLOT_W-1:0]            slot,
	output logic [dpt_pkg::COORD_BITS-1:0]        entry_x,
	output logic [dpt_pkg::COORD_BITS-1:0]        entry_y,
	output logic [dpt_pkg::REM_W-1:0]             removed_count
);

	logic [dpt_pkg::MARGIN_W-1:0]  margin_q;
	logic [dpt_pkg::CONFIRM_W-1:0] confirm_q;

	logic                          busy_q;
	logic                          fin_valid_q;
	dpt_pkg::wave_t                fin_q;
	logic                          out_valid_q;
	dpt_pkg::event_t               ev_q;
	logic [dpt_pkg::SLOT_W-1:0]    slot_q;
	dpt_pkg::coord_t               x_q;
	dpt_pkg::coord_t               y_q;
	logic [dpt_pkg::REM_W-1:0]     rem_q;

	dpt_pkg::wave_t                chain [dpt_pkg::ENTRIES+1];
	dpt_pkg::alloc_t               alloc;
	logic                          accept;
	logic                          absorb;

	dpt_pkg::event_t               ev_d;
	dpt_pkg::idx_t                 slot_idx;
	logic [dpt_pkg::SLOT_W+dpt_pkg::IDX_BITS-1:0] slot_ext;
	dpt_pkg::coord_t               x_d;
	dpt_pkg::coord_t               y_d;
	logic [dpt_pkg::REM_W+dpt_pkg::CNT_BITS-1:0]  freed_ext;
	logic [dpt_pkg::REM_W-1:0]     rem_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q  <= dpt_pkg::MARGIN_RESET;
			confirm_q <= dpt_pkg::CONFIRM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dpt_pkg::CFG_MATCH_MARGIN:  margin_q  <= cfg_data[dpt_pkg::MARGIN_W-1:0];
				dpt_pkg::CFG_CONFIRM_COUNT: confirm_q <= cfg_data[dpt_pkg::CONFIRM_W-1:0];
				default: ;
			endcase
		end
	end

	// Only one word walks the row at a time.
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign absorb   = fin_valid_q && (!out_valid_q || out_ready);

	// The first cell sees the accepted input word directly.
	always_comb begin
		chain[0]           = '0;
		chain[0].active    = accept;
		chain[0].action    = action;
		chain[0].px        = point_x;
		chain[0].py        = point_y;
		chain[0].ev        = dpt_pkg::EV_MATCHED;
	end

	for (genvar i = 0; i < dpt_pkg::ENTRIES; i++) begin : g_cell
		dpt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (dpt_pkg::idx_t'(i)),
			.margin   (margin_q),
			.confirm  (confirm_q),
			.wave_in  (chain[i]),
			.alloc    (alloc),
			.wave_out (chain[i+1])
		);
	end

	// Decide the result of a finished walk. A point with no match but a
	// free slot opens the entry in the same cycle that the result moves on.
	always_comb begin
		alloc     = '0;
		ev_d      = dpt_pkg::EV_TABLE_FULL;
		slot_idx  = '0;
		x_d       = '0;
		y_d       = '0;
		rem_d     = '0;
		freed_ext = {{dpt_pkg::REM_W{1'b0}}, fin_q.freed};
		if (fin_q.action == dpt_pkg::ACT_EOF) begin
			ev_d  = dpt_pkg::EV_FRAME_CLOSED;
			rem_d = (freed_ext > (dpt_pkg::REM_W + dpt_pkg::CNT_BITS)'(dpt_pkg::REM_MAX))
				? dpt_pkg::REM_MAX : freed_ext[dpt_pkg::REM_W-1:0];
		end else if (fin_q.found) begin
			ev_d     = fin_q.ev;
			slot_idx = fin_q.hit_slot;
			x_d      = fin_q.hit_x;
			y_d      = fin_q.hit_y;
		end else if (fin_q.have_free) begin
			ev_d      = dpt_pkg::EV_NEW_ENTRY;
			slot_idx  = fin_q.free_slot;
			x_d       = fin_q.px;
			y_d       = fin_q.py;
			alloc.en  = absorb;
			alloc.slot = fin_q.free_slot;
			alloc.x   = fin_q.px;
			alloc.y   = fin_q.py;
		end
		slot_ext = {{dpt_pkg::SLOT_W{1'b0}}, slot_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (absorb)
				busy_q <= 1'b0;
			if (chain[dpt_pkg::ENTRIES].active)
				fin_valid_q <= 1'b1;
			else if (absorb)
				fin_valid_q <= 1'b0;
			if (absorb)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[dpt_pkg::ENTRIES].active)
			fin_q <= chain[dpt_pkg::ENTRIES];
		if (absorb) begin
			ev_q   <= ev_d;
			slot_q <= slot_ext[dpt_pkg::SLOT_W-1:0];
			x_q    <= x_d;
			y_q    <= y_d;
			rem_q  <= rem_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = ev_q;
	assign slot          = slot_q;
	assign entry_x       = x_q;
	assign entry_y       = y_q;
	assign removed_count = rem_q;

endmodule

FILE: design/dpt_checker.sv
// Port-level checker for the detection persistence table, bound to the top level.
module dpt_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [dpt_pkg::EVENT_W-1:0]           event_res,
	input  logic [dpt_pkg::SLOT_W-1:0]            slot,
	input  logic [dpt_pkg::COORD_BITS-1:0]        entry_x,
	input  logic [dpt_pkg::COORD_BITS-1:0]        entry_y,
	input  logic [dpt_pkg::REM_W-1:0]             removed_count
);

	// After a taken word the block is busy and refuses further input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after an accepted word");

	// No result can appear in the cycle after a word is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared one cycle after accept");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(event_res)
			&& $stable(slot) && $stable(entry_x) && $stable(entry_y)
			&& $stable(removed_count)))
		else $error("stalled result changed");

	// A frame close touches no slot.
	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == dpt_pkg::EV_FRAME_CLOSED))
			|-> (slot == '0 && entry_x == '0 && entry_y == '0))
		else $error("frame close carries slot data");

	// Only a frame close reports freed entries.
	a_removed_only_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res != dpt_pkg::EV_FRAME_CLOSED)) |-> (removed_count == '0))
		else $error("point result reports freed entries");

endmodule

bind detection_persistence_table_core dpt_checker u_dpt_checker (.*);

FILE: bench/detection_persistence_table_core_test.sv
// Self-checking testbench for the detection persistence table core.
`timescale 1ns / 100ps

module detection_persistence_table_core_test;

	import dpt_pkg::*;

	// Longest run of cycles in which nothing moves before the run is declared hung.
	// The long receiver hold-off (LONG_HOLD) and the settle time between phases
	// both stay well below it.
	localparam int STALL_LIMIT = 2000;
	// Cycles granted after the last result, a little more than the walk latency.
	localparam int SETTLE      = ENTRIES + 4;
	// The receiver stops taking results after this many; LONG_HOLD sets how long.
	localparam int HOLD_AT     = 150;
	localparam int LONG_HOLD   = 300;

	// One word on the input channel.
	typedef struct packed {
		logic   action;
		coord_t px;
		coord_t py;
	} det_word_t;

	// One word on the result channel, as the table is expected to answer.
	typedef struct packed {
		event_t           ev;
		logic [SLOT_W-1:0] slot;
		coord_t           x;
		coord_t           y;
		logic [REM_W-1:0] removed;
	} track_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = ACT_POINT;
	coord_t                point_x = '0;
	coord_t                point_y = '0;

	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [EVENT_W-1:0]    event_res;
	logic [SLOT_W-1:0]     slot;
	coord_t                entry_x;
	coord_t                entry_y;
	logic [REM_W-1:0]      removed_count;

	// Words waiting to be offered, and results the table owes us, oldest first.
	det_word_t     detect_words[$];
	track_result_t expected_events[$];

	// Our own copy of the track table and of the two registers.
	logic               trk_valid[ENTRIES];
	coord_t             trk_x[ENTRIES];
	coord_t             trk_y[ENTRIES];
	logic [HIT_W-1:0]   trk_hits[ENTRIES];
	logic               trk_seen[ENTRIES];
	logic [MARGIN_W-1:0]  margin_q  = MARGIN_RESET;
	logic [CONFIRM_W-1:0] confirm_q = CONFIRM_RESET;

	int mismatches   = 0;
	int results_seen = 0;
	int idle_cycles  = 0;

	detection_persistence_table_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.point_x       (point_x),
		.point_y       (point_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_res     (event_res),
		.slot          (slot),
		.entry_x       (entry_x),
		.entry_y       (entry_y),
		.removed_count (removed_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			trk_valid[i] = 1'b0;
			trk_seen[i]  = 1'b0;
			trk_x[i]     = '0;
			trk_y[i]     = '0;
			trk_hits[i]  = '0;
		end
	end

	// True when one coordinate lies strictly inside the match window.
	function automatic bit near_axis(input coord_t a, input coord_t b);
		int d;
		d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
		return d < int'(margin_q);
	endfunction

	// Applies one accepted word to the track table and returns the answer it owes.
	function automatic track_result_t track_update(input det_word_t w);
		track_result_t r;
		int freed;
		bit found;
		bit have_free;
		int hit;
		int free_slot;
		r.ev      = EV_MATCHED;
		r.slot    = '0;
		r.x       = '0;
		r.y       = '0;
		r.removed = '0;
		found     = 1'b0;
		have_free = 1'b0;
		hit       = 0;
		free_slot = 0;
		freed     = 0;
		if (w.action == ACT_EOF) begin
			// Age every entry that went unseen this frame and drop the ones that run out.
			for (int i = 0; i < ENTRIES; i++) begin
				if (trk_valid[i] && !trk_seen[i]) begin
					if (trk_hits[i] <= 1) begin
						trk_hits[i]  = '0;
						trk_valid[i] = 1'b0;
						freed++;
					end else begin
						trk_hits[i] = trk_hits[i] - 1'b1;
					end
				end
				trk_seen[i] = 1'b0;
			end
			if (freed > 31)
				freed = 31;
			r.ev      = EV_FRAME_CLOSED;
			r.removed = REM_W'(freed);
			return r;
		end
		// Every entry inside the window is marked seen; the lowest one takes the hit.
		for (int i = 0; i < ENTRIES; i++) begin
			if (trk_valid[i]) begin
				if (near_axis(w.px, trk_x[i]) && near_axis(w.py, trk_y[i])) begin
					trk_seen[i] = 1'b1;
					if (!found) begin
						found = 1'b1;
						hit   = i;
					end
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_slot = i;
			end
		end
		if (found) begin
			if (trk_hits[hit] < confirm_q) begin
				trk_hits[hit] = trk_hits[hit] + 1'b1;
				if (trk_hits[hit] == confirm_q)
					r.ev = EV_CONFIRMED;
			end
			r.slot = SLOT_W'(hit);
			r.x    = trk_x[hit];
			r.y    = trk_y[hit];
		end else if (have_free) begin
			trk_valid[free_slot] = 1'b1;
			trk_x[free_slot]     = w.px;
			trk_y[free_slot]     = w.py;
			trk_hits[free_slot]  = HIT_W'(1);
			trk_seen[free_slot]  = 1'b1;
			r.ev   = EV_NEW_ENTRY;
			r.slot = SLOT_W'(free_slot);
			r.x    = w.px;
			r.y    = w.py;
		end else begin
			r.ev = EV_TABLE_FULL;
		end
		return r;
	endfunction

	// Queues one input word; coordinates wrap into the table's range.
	task automatic push_word(input logic act, input int x, input int y);
		det_word_t w;
		w.action = act;
		w.px     = coord_t'(x);
		w.py     = coord_t'(y);
		detect_words.push_back(w);
	endtask

	// Drives one register write on the port and mirrors it in our copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MATCH_MARGIN)
			margin_q = MARGIN_W'(value);
		else
			confirm_q = CONFIRM_W'(value);
	endtask

	// Blocks until every queued word was taken and answered, then lets the row drain.
	task automatic wait_idle();
		@(negedge clk);
		while (!(detect_words.size() == 0 && !in_valid && expected_events.size() == 0))
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Builds frames of a small scene of moving objects: most words are points that
	// land near a tracked object, followed by an end-of-frame word. Some frames carry
	// stray points anywhere in the field, lose their end-of-frame word, or come empty.
	task automatic gen_tracking_phase(input int n_items);
		int obj_x[$];
		int obj_y[$];
		int made;
		int jit;
		int m;
		int n_obj;
		int k;
		made  = 0;
		m     = int'(margin_q);
		jit   = (m > 1) ? ((m - 1 > 6) ? 6 : m - 1) : 0;
		n_obj = $urandom_range(1, 12);
		for (k = 0; k < n_obj; k++) begin
			obj_x.push_back($urandom_range(0, 1023));
			obj_y.push_back($urandom_range(0, 1023));
		end
		while (made < n_items) begin
			for (k = 0; k < obj_x.size(); k++) begin
				if ($urandom_range(0, 9) < 8) begin
					push_word(ACT_POINT,
						obj_x[k] + int'($urandom_range(0, 2 * jit)) - jit,
						obj_y[k] + int'($urandom_range(0, 2 * jit)) - jit);
					made++;
				end
				obj_x[k] = obj_x[k] + int'($urandom_range(0, 4)) - 2;
				obj_y[k] = obj_y[k] + int'($urandom_range(0, 4)) - 2;
			end
			if ($urandom_range(0, 3) == 0) begin
				push_word(ACT_POINT, $urandom_range(0, 1023), $urandom_range(0, 1023));
				made++;
			end
			if ($urandom_range(0, 5) == 0 && obj_x.size() > 0) begin
				k = $urandom_range(0, obj_x.size() - 1);
				obj_x.delete(k);
				obj_y.delete(k);
			end
			if ($urandom_range(0, 4) == 0 && obj_x.size() < 20) begin
				obj_x.push_back($urandom_range(0, 1023));
				obj_y.push_back($urandom_range(0, 1023));
			end
			if ($urandom_range(0, 9) != 0) begin
				push_word(ACT_EOF, 0, 0);
				made++;
			end
			if ($urandom_range(0, 19) == 0) begin
				push_word(ACT_EOF, $urandom_range(0, 1023), $urandom_range(0, 1023));
				made++;
			end
		end
	endtask

	// Offers queued words. A new word is loaded only when the channel is free, so
	// valid and the payload hold steady until the table takes the word. Each taken
	// word is run through our table copy at the same edge the table takes it.
	always @(posedge clk or negedge arst_n) begin : word_driver
		det_word_t w;
		int gap_left;
		int burst_left;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				w.action = action;
				w.px     = point_x;
				w.py     = point_y;
				expected_events.push_back(track_update(w));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (detect_words.size() > 0) begin
					w = detect_words.pop_front();
					action   <= w.action;
					point_x  <= w.px;
					point_y  <= w.py;
					in_valid <= 1'b1;
					// Now and then a run of back-to-back words, otherwise a short pause.
					if (burst_left > 0) begin
						burst_left--;
						gap_left = 0;
					end else begin
						gap_left = $urandom_range(0, 4);
						if ($urandom_range(0, 9) == 0)
							burst_left = $urandom_range(10, 30);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Takes result words and checks each one against the oldest expectation.
	// After HOLD_AT results the receiver goes deaf for a long stretch so that the
	// holding register fills and the table has to refuse input.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		track_result_t want;
		logic fire;
		int wait_left;
		int hold_left;
		int burst_left;
		int w;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			wait_left  = 0;
			hold_left  = 0;
			burst_left = 0;
		end else begin
			fire = out_valid && out_ready;
			if (fire) begin
				results_seen++;
				if (expected_events.size() == 0) begin
					$error("result word with no word pending: event_res %0d slot %0d",
						event_res, slot);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (event_res !== want.ev) begin
						$error("event_res expected %0d got %0d", want.ev, event_res);
						mismatches++;
					end
					if (slot !== want.slot) begin
						$error("slot expected %0d got %0d", want.slot, slot);
						mismatches++;
					end
					if (entry_x !== want.x) begin
						$error("entry_x expected %0d got %0d", want.x, entry_x);
						mismatches++;
					end
					if (entry_y !== want.y) begin
						$error("entry_y expected %0d got %0d", want.y, entry_y);
						mismatches++;
					end
					if (removed_count !== want.removed) begin
						$error("removed_count expected %0d got %0d", want.removed,
							removed_count);
						mismatches++;
					end
				end
			end
			if (fire && results_seen == HOLD_AT) begin
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= (hold_left == 0);
			end else if (fire) begin
				if (burst_left > 0) begin
					burst_left--;
					w = 0;
				end else begin
					w = $urandom_range(0, 4);
					if ($urandom_range(0, 9) == 0)
						burst_left = $urandom_range(10, 30);
				end
				wait_left = w;
				out_ready <= (w == 0);
			end else if (wait_left > 0) begin
				wait_left--;
				out_ready <= (wait_left == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Ends the run if neither channel nor the register port moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Register settings for the random phases: zero and full margin, exact-match
	// margin, confirmation at one, at zero and at the top of the range.
	int margins[7]  = '{0, 1023, 1, 8, 512, 20, 37};
	int confirms[7] = '{3, 15, 1, 0, 4, 10, 2};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening with the reset settings (margin 20, confirm 10).
		push_word(ACT_POINT, 0, 0);         // first entry in slot 0
		push_word(ACT_POINT, 1023, 1023);   // far corner opens slot 1
		push_word(ACT_POINT, 19, 19);       // one inside the window: hit on slot 0
		push_word(ACT_POINT, 20, 0);        // exactly on the margin: no match, new entry
		push_word(ACT_POINT, 1004, 1023);   // hit on slot 1
		push_word(ACT_EOF, 0, 0);           // everything was seen, nothing ages
		push_word(ACT_EOF, 0, 0);           // ages all; the single-hit entry goes
		push_word(ACT_EOF, 1023, 1023);     // the remaining two run out
		for (int k = 0; k < ENTRIES; k++)
			push_word(ACT_POINT, k * 64, 512);
		push_word(ACT_POINT, 1000, 100);    // no slot left: table full
		push_word(ACT_EOF, 0, 0);           // fresh entries were seen, none age
		push_word(ACT_EOF, 0, 0);           // all sixteen are freed at once
		gen_tracking_phase(78);
		wait_idle();

		// Each further phase starts from an idle table with new register values.
		for (int p = 0; p < 7; p++) begin
			write_reg(CFG_MATCH_MARGIN, margins[p]);
			write_reg(CFG_CONFIRM_COUNT, confirms[p]);
			@(negedge clk);
			gen_tracking_phase(78);
			wait_idle();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
